@@ src/prdl_pkg.sv @@
`timescale 1ns / 1ps
// prdl_pkg: shared types and constants for the dark/light pixel recolouring block.
// No dependencies.
package prdl_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DARK_COLOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_COLOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_HUE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOLOR_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_VIDEO  = 3'd4;

	localparam logic [23:0] DARK_COLOR_RST  = 24'hFF_FFFF;
	localparam logic [23:0] LIGHT_COLOR_RST = 24'h00_0000;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic       in_image;
		logic       end_of_row;
		logic       end_of_page;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       row_done;
		logic       page_done;
	} pix_out_t;

endpackage

@@ src/prdl_div.sv @@
`timescale 1ns / 1ps
// prdl_div: pipelined restoring divider, one quotient bit per stage, with side payload.
// No dependencies.
module prdl_div #(
	parameter int QW = 33,
	parameter int DW = 17,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [DW-1:0] rem_in,   // must be below den_in
	input  logic [QW-1:0] num_in,
	input  logic [DW-1:0] den_in,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_stage
			logic          vld_s;
			logic [DW-1:0] rem_s;
			logic [QW-1:0] num_s;
			logic [QW-1:0] quo_s;
			logic [DW-1:0] den_s;
			logic [SW-1:0] side_s;
			logic          pv;
			logic [DW-1:0] pr;
			logic [DW-1:0] pd;
			logic [QW-1:0] pn;
			logic [QW-1:0] pq;
			logic [SW-1:0] ps;
			logic [DW:0]   t;
			logic          ge;

			if (i == 0) begin : g_first
				assign pv = vld_in;
				assign pr = rem_in;
				assign pd = den_in;
				assign pn = num_in;
				assign pq = '0;
				assign ps = side_in;
			end else begin : g_next
				assign pv = g_stage[i-1].vld_s;
				assign pr = g_stage[i-1].rem_s;
				assign pd = g_stage[i-1].den_s;
				assign pn = g_stage[i-1].num_s;
				assign pq = g_stage[i-1].quo_s;
				assign ps = g_stage[i-1].side_s;
			end

			assign t  = {pr, pn[QW-1]};
			assign ge = (t >= {1'b0, pd});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s <= 1'b0;
				end else if (en) begin
					vld_s <= pv;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s  <= ge ? DW'(t - {1'b0, pd}) : DW'(t);
					num_s  <= pn << 1;
					quo_s  <= {pq[QW-2:0], ge};
					den_s  <= pd;
					side_s <= ps;
				end
			end
		end
	endgenerate

	assign vld_out  = g_stage[QW-1].vld_s;
	assign quo      = g_stage[QW-1].quo_s;
	assign side_out = g_stage[QW-1].side_s;

endmodule

@@ src/pixel_recolor_dark_light_top.sv @@
`timescale 1ns / 1ps
// pixel_recolor_dark_light_top: per-pixel dark/light recolouring pipeline.
// Depends on prdl_pkg and prdl_div.
//
// Usage:
//  - Input channel in_valid/in_ready/in_pix carries one RGB pixel per transaction with
//    its image flag and row/page marks; output channel out_valid/out_ready/out_pix
//    returns exactly one recoloured pixel per input transaction, in order.
//  - Configuration: cfg_we/cfg_idx/cfg_data write one register per cycle; write only
//    while the pipeline is empty. Indexes beyond the register list are ignored.
//  - Throughput: one transaction per cycle while no stall holds the pipeline. The depth
//    is mostly set by the two dividers: the saturation bound divider of
//    2*FRAC_BITS+1 bit stages and the ratio divider of FRAC_BITS bit stages.
//  - Plain mode and pass-through pixels travel down the same pipeline, so order and
//    latency do not depend on the mode.
//  - Stall: when out_ready is low with a result held, every stage freezes together and
//    in_ready drops; nothing is lost or repeated. A held result stays stable.
//  - Reset (arst_n low) empties the pipeline and loads the register defaults:
//    dark white, light black, hue mode on, recolouring off, reverse video off.
module pixel_recolor_dark_light_top #(
	parameter int FRAC_BITS = prdl_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [prdl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [prdl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  prdl_pkg::pix_in_t                   in_pix,
	output logic                                out_valid,
	input  logic                                out_ready,
	output prdl_pkg::pix_out_t                  out_pix
);

	// ---------------------------------------------------------------------------------
	// Widths and constants (all Q(F) fixed point)
	// ---------------------------------------------------------------------------------
	localparam int F     = FRAC_BITS;
	localparam int PW    = F + 1;          // 0..ONE
	localparam int HW    = F + 2;          // signed, +/-ONE
	localparam int LW    = 2 * F + 1;      // weighted products, bound numerator
	localparam int XW    = 2 * PW;         // cross products
	localparam int LDW   = 2 * F + 3;      // l*dL
	localparam int PMW   = F + 11;         // plain-mode products
	localparam int UW    = (2 * F + 1 > F + 20) ? 2 * F + 1 : F + 20;  // bounds incl. cap
	localparam int LO    = (UW + 1) / 2;
	localparam int HI    = UW - LO;
	localparam int VW    = PW + UW;
	localparam int RHW   = 2 * F + 4;
	localparam int YW    = 2 * F + 12;
	localparam int ONE_I = 1 << F;
	localparam int W0    = (30 * ONE_I + 50) / 100;
	localparam int W1    = (59 * ONE_I + 50) / 100;
	localparam int W2    = ONE_I - W0 - W1;
	localparam int FA    = ONE_I / 255;
	localparam int FB    = ONE_I % 255;

	localparam logic [PW-1:0] ONE     = PW'(ONE_I);
	localparam logic [LW-1:0] HALF_LW = LW'(ONE_I / 2);
	localparam logic [UW-1:0] CAP     = UW'(64'd1000000 << F);
	localparam logic [19:0]   MILLION = 20'd1000000;
	localparam logic [LW-1:0] WT [3]  = '{LW'(W0), LW'(W1), LW'(W2)};
	// pairs compared when looking for the tightest bound
	localparam int PI [3] = '{0, 0, 1};
	localparam int PJ [3] = '{1, 2, 2};

	typedef enum logic [1:0] {R_ZERO, R_ONE, R_DIV} rmode_t;

	// payload that rides alongside the arithmetic
	typedef struct packed {
		prdl_pkg::pix_in_t     pix;
		logic                  pass;
		logic [2:0][7:0]       pln;   // plain-mode result
		logic [2:0][HW-1:0]    h;     // chroma vector
		logic [HW-1:0]         lp;    // remapped lightness
		logic [PW-1:0]         adl;   // |dL|
		logic                  any;   // not grey
	} car_t;

	typedef struct packed {
		car_t car;
		logic cap;
	} hs_t;

	typedef struct packed {
		car_t   car;
		rmode_t mode;
	} rs_t;

	// c*ONE/255 rounded, as c*FA + (c*FB+127)/255; the small quotient by reciprocal
	function automatic logic [PW-1:0] frac_of(input logic [7:0] c);
		logic [15:0] y;
		logic [24:0] e;
		logic [7:0]  q;
		logic [15:0] rr;
		y  = 16'(c * FB + 127);
		e  = 25'(y) * 25'd257;
		q  = 8'(e >> 16);
		rr = y - 16'(q) * 16'd255;
		if (rr >= 16'd255) begin
			q = q + 8'd1;
		end
		return PW'(c * FA) + PW'(q);
	endfunction

	// ---------------------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------------------
	logic [23:0] dark_q, light_q;
	logic        keep_q, ena_q, rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= prdl_pkg::DARK_COLOR_RST;
			light_q <= prdl_pkg::LIGHT_COLOR_RST;
			keep_q  <= 1'b1;
			ena_q   <= 1'b0;
			rev_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				prdl_pkg::CFG_DARK_COLOR:     dark_q  <= cfg_data;
				prdl_pkg::CFG_LIGHT_COLOR:    light_q <= cfg_data;
				prdl_pkg::CFG_KEEP_HUE:       keep_q  <= cfg_data[0];
				prdl_pkg::CFG_RECOLOR_ENABLE: ena_q   <= cfg_data[0];
				prdl_pkg::CFG_REVERSE_VIDEO:  rev_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [7:0] dc [3];
	logic [7:0] lc [3];
	logic [7:0] cin [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dc[k] = dark_q[16 - 8 * k +: 8];
			lc[k] = light_q[16 - 8 * k +: 8];
		end
		cin[0] = in_pix.in_red;
		cin[1] = in_pix.in_green;
		cin[2] = in_pix.in_blue;
	end

	// ---------------------------------------------------------------------------------
	// Flow control: the whole pipe moves together unless a held result is not taken
	// ---------------------------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15, vld_s16;
	logic vd0, vd1, vdr;

	assign adv      = !vld_s16 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0; vld_s2  <= 1'b0; vld_s3  <= 1'b0; vld_s4  <= 1'b0;
			vld_s5  <= 1'b0; vld_s6  <= 1'b0; vld_s7  <= 1'b0; vld_s8  <= 1'b0;
			vld_s9  <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			vld_s13 <= 1'b0; vld_s14 <= 1'b0; vld_s15 <= 1'b0; vld_s16 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vd0 & vd1;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vdr;
			vld_s15 <= vld_s14;
			vld_s16 <= vld_s15;
		end
	end

	// ---------------------------------------------------------------------------------
	// S1..S3: components to fractions, weighted sums, lightness of pixel/dark/light
	// group 0 = pixel, 1 = dark colour, 2 = light colour
	// ---------------------------------------------------------------------------------
	car_t          car_s1, car_s2, car_s3, car_s4, car_s5, car_s6, car_s7, car_s8, car_s9;
	logic [PW-1:0] p_s1  [3][3];
	logic [LW-1:0] w_s2  [3][3];
	logic [PW-1:0] pp_s2 [3];
	logic [PW-1:0] pp_s3 [3];
	logic [PW-1:0] lt_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s1      <= '0;
			car_s1.pix  <= in_pix;
			car_s1.pass <= !ena_q || (rev_q && in_pix.in_image);
			for (int k = 0; k < 3; k++) begin
				p_s1[0][k] <= frac_of(cin[k]);
				p_s1[1][k] <= frac_of(dc[k]);
				p_s1[2][k] <= frac_of(lc[k]);
			end

			car_s2 <= car_s1;
			for (int g = 0; g < 3; g++) begin
				for (int k = 0; k < 3; k++) begin
					w_s2[g][k] <= WT[k] * LW'(p_s1[g][k]);
				end
			end
			for (int k = 0; k < 3; k++) begin
				pp_s2[k] <= p_s1[0][k];
			end

			car_s3 <= car_s2;
			for (int g = 0; g < 3; g++) begin
				lt_s3[g] <= PW'((w_s2[g][0] + w_s2[g][1] + w_s2[g][2] + HALF_LW) >> F);
			end
			pp_s3 <= pp_s2;
		end
	end

	// ---------------------------------------------------------------------------------
	// S4: chroma, dL, plain-mode products, l*dL
	// ---------------------------------------------------------------------------------
	logic signed [HW-1:0]  dl_c;
	logic signed [HW-1:0]  h_s4  [3];
	logic signed [PMW-1:0] pm_s4 [3];
	logic signed [LDW-1:0] ldl_s4;
	logic signed [HW-1:0]  dl_s4;
	logic [PW-1:0]         l_s4, l1_s4;

	assign dl_c = $signed({1'b0, lt_s3[2]}) - $signed({1'b0, lt_s3[1]});

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s4 <= car_s3;
			for (int k = 0; k < 3; k++) begin
				h_s4[k]  <= $signed({1'b0, pp_s3[k]}) - $signed({1'b0, lt_s3[0]});
				pm_s4[k] <= $signed({1'b0, lt_s3[0]}) *
					($signed({2'b0, lc[k]}) - $signed({2'b0, dc[k]}));
			end
			ldl_s4 <= $signed({1'b0, lt_s3[0]}) * dl_c;
			dl_s4  <= dl_c;
			l_s4   <= lt_s3[0];
			l1_s4  <= lt_s3[1];
		end
	end

	// ---------------------------------------------------------------------------------
	// S5: plain result, remapped lightness l', bound terms for l
	// ---------------------------------------------------------------------------------
	car_t          car_c5;
	logic [PW-1:0] num0_c [3];
	logic [PW-1:0] den_c  [3];
	logic          nz_c   [3];

	always_comb begin
		logic           neg;
		logic [LDW-1:0] mag;
		logic [LDW-1:0] rq;
		logic [PMW-1:0] px;
		logic [PMW-1:0] pq;
		logic [HW-1:0]  hk;
		logic           hpos;
		car_c5 = car_s4;
		neg    = ldl_s4[LDW-1];
		mag    = neg ? LDW'(-ldl_s4) : LDW'(ldl_s4);
		rq     = (mag + LDW'(ONE_I / 2)) >> F;
		car_c5.lp  = HW'(LDW'({1'b0, l1_s4}) + (neg ? -rq : rq));
		car_c5.adl = dl_s4[HW-1] ? PW'(-dl_s4) : PW'(dl_s4);
		for (int k = 0; k < 3; k++) begin
			px = PMW'(pm_s4[k]) + (PMW'(dc[k]) << F);
			pq = (px + PMW'(ONE_I / 2)) >> F;
			if (px[PMW-1]) begin
				car_c5.pln[k] = 8'd0;
			end else if (pq > PMW'(255)) begin
				car_c5.pln[k] = 8'hFF;
			end else begin
				car_c5.pln[k] = pq[7:0];
			end
			hk            = h_s4[k];
			car_c5.h[k]   = hk;
			nz_c[k]       = (hk != '0);
			hpos          = !hk[HW-1] && nz_c[k];
			num0_c[k]     = hpos ? ONE - l_s4 : l_s4;
			den_c[k]      = hk[HW-1] ? PW'(-hk) : PW'(hk);
		end
		car_c5.any = nz_c[0] || nz_c[1] || nz_c[2];
	end

	logic [PW-1:0] num0_s5 [3];
	logic [PW-1:0] den_s5  [3];
	logic          nz_s5   [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s5  <= car_c5;
			num0_s5 <= num0_c;
			den_s5  <= den_c;
			nz_s5   <= nz_c;
		end
	end

	// ---------------------------------------------------------------------------------
	// S6: bound terms for l'
	// ---------------------------------------------------------------------------------
	logic [PW-1:0] num1_c [3];

	always_comb begin
		logic [HW-1:0] a;
		logic [HW-1:0] hk;
		for (int k = 0; k < 3; k++) begin
			hk        = car_s5.h[k];
			a         = (!hk[HW-1] && hk != '0) ? HW'(ONE_I) - car_s5.lp : car_s5.lp;
			num1_c[k] = a[HW-1] ? PW'(-a) : PW'(a);
		end
	end

	logic [PW-1:0] nm_s6  [2][3];
	logic [PW-1:0] den_s6 [3];
	logic          nz_s6  [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s6    <= car_s5;
			nm_s6[0]  <= num0_s5;
			nm_s6[1]  <= num1_c;
			den_s6    <= den_s5;
			nz_s6     <= nz_s5;
		end
	end

	// ---------------------------------------------------------------------------------
	// S7: cross products to rank num/den ratios without dividing
	// ---------------------------------------------------------------------------------
	logic [XW-1:0] xa_s7  [2][3];
	logic [XW-1:0] xb_s7  [2][3];
	logic [PW-1:0] nm_s7  [2][3];
	logic [PW-1:0] den_s7 [3];
	logic          nz_s7  [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s7 <= car_s6;
			for (int b = 0; b < 2; b++) begin
				for (int m = 0; m < 3; m++) begin
					xa_s7[b][m] <= XW'(nm_s6[b][PI[m]]) * XW'(den_s6[PJ[m]]);
					xb_s7[b][m] <= XW'(nm_s6[b][PJ[m]]) * XW'(den_s6[PI[m]]);
				end
			end
			nm_s7  <= nm_s6;
			den_s7 <= den_s6;
			nz_s7  <= nz_s6;
		end
	end

	// ---------------------------------------------------------------------------------
	// S8: pick the tightest bound among the non-zero chroma components
	// ---------------------------------------------------------------------------------
	logic [PW-1:0] nmin_c [2];
	logic [PW-1:0] dmin_c [2];

	always_comb begin
		logic le01, le02, le12;
		for (int b = 0; b < 2; b++) begin
			le01 = xa_s7[b][0] <= xb_s7[b][0];
			le02 = xa_s7[b][1] <= xb_s7[b][1];
			le12 = xa_s7[b][2] <= xb_s7[b][2];
			priority if (nz_s7[0] && (!nz_s7[1] || le01) && (!nz_s7[2] || le02)) begin
				nmin_c[b] = nm_s7[b][0];
				dmin_c[b] = den_s7[0];
			end else if (nz_s7[1] && (!nz_s7[2] || le12)) begin
				nmin_c[b] = nm_s7[b][1];
				dmin_c[b] = den_s7[1];
			end else begin
				nmin_c[b] = nm_s7[b][2];
				dmin_c[b] = den_s7[2];
			end
		end
	end

	logic [PW-1:0] nmin_s8 [2];
	logic [PW-1:0] dmin_s8 [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s8  <= car_s7;
			nmin_s8 <= nmin_c;
			dmin_s8 <= dmin_c;
		end
	end

	// ---------------------------------------------------------------------------------
	// S9: cap test (quotient reaches CAP exactly when num >= 1e6*den), divider operands
	// ---------------------------------------------------------------------------------
	logic [LW-1:0] dnum_s9 [2];
	logic [PW-1:0] dden_s9 [2];
	logic          cap_s9  [2];

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s9 <= car_s8;
			for (int b = 0; b < 2; b++) begin
				dnum_s9[b] <= LW'(nmin_s8[b]) << F;
				dden_s9[b] <= (dmin_s8[b] == '0) ? PW'(1) : dmin_s8[b];
				cap_s9[b]  <= !((PW + 20)'(nmin_s8[b]) <
					((PW + 20)'(dmin_s8[b]) * (PW + 20)'(MILLION)));
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Bound dividers: u0 for l, u1 for l' (2F+1 stages each, run side by side)
	// ---------------------------------------------------------------------------------
	hs_t           hs_in, hs_out;
	logic [LW-1:0] q0, q1;
	logic          cap1_out;

	assign hs_in = '{car: car_s9, cap: cap_s9[0]};

	prdl_div #(.QW(LW), .DW(PW), .SW($bits(hs_t))) u_div_u0 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s9),
		.rem_in   ('0),
		.num_in   (dnum_s9[0]),
		.den_in   (dden_s9[0]),
		.side_in  (hs_in),
		.vld_out  (vd0),
		.quo      (q0),
		.side_out (hs_out)
	);

	prdl_div #(.QW(LW), .DW(PW), .SW(1)) u_div_u1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s9),
		.rem_in   ('0),
		.num_in   (dnum_s9[1]),
		.den_in   (dden_s9[1]),
		.side_in  (cap_s9[1]),
		.vld_out  (vd1),
		.quo      (q1),
		.side_out (cap1_out)
	);

	// ---------------------------------------------------------------------------------
	// S10..S13: apply caps, tighten u1 by |dL|*u0, choose how r is formed
	// ---------------------------------------------------------------------------------
	car_t             car_s10, car_s11, car_s12;
	logic [UW-1:0]    u0_s10, u1_s10, u0_s11, u1_s11, u0_s12, u1_s12;
	logic [PW+LO-1:0] pa_s11;
	logic [PW+HI-1:0] pb_s11;
	logic [VW-1:0]    vfull;
	logic [VW-1:0]    vv;

	assign vfull = VW'(pa_s11) + (VW'(pb_s11) << LO);
	assign vv    = vfull >> F;

	always_ff @(posedge clk) begin
		if (adv) begin
			car_s10 <= hs_out.car;
			u0_s10  <= hs_out.cap ? CAP : UW'(q0);
			u1_s10  <= cap1_out ? CAP : UW'(q1);

			car_s11 <= car_s10;
			pa_s11  <= (PW + LO)'(car_s10.adl) * (PW + LO)'(u0_s10[LO-1:0]);
			pb_s11  <= (PW + HI)'(car_s10.adl) * (PW + HI)'(u0_s10[UW-1:LO]);
			u0_s11  <= u0_s10;
			u1_s11  <= u1_s10;

			car_s12 <= car_s11;
			u0_s12  <= u0_s11;
			u1_s12  <= (vv < VW'(u1_s11)) ? UW'(vv) : u1_s11;
		end
	end

	rs_t           rs_s13, rs_out;
	logic [UW-1:0] rrem_s13, rden_s13;
	logic [F-1:0]  rq;

	always_ff @(posedge clk) begin
		if (adv) begin
			rs_s13.car <= car_s12;
			priority if (!car_s12.any || u0_s12 == '0) begin
				rs_s13.mode <= R_ZERO;
				rrem_s13    <= '0;
			end else if (u1_s12 >= u0_s12) begin
				rs_s13.mode <= R_ONE;
				rrem_s13    <= '0;
			end else begin
				rs_s13.mode <= R_DIV;
				rrem_s13    <= u1_s12;
			end
			rden_s13 <= (u0_s12 == '0) ? UW'(1) : u0_s12;
		end
	end

	// r = u1*ONE/u0 as a pure fraction, F stages
	prdl_div #(.QW(F), .DW(UW), .SW($bits(rs_t))) u_div_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s13),
		.rem_in   (rrem_s13),
		.num_in   ('0),
		.den_in   (rden_s13),
		.side_in  (rs_s13),
		.vld_out  (vdr),
		.quo      (rq),
		.side_out (rs_out)
	);

	// ---------------------------------------------------------------------------------
	// S14..S16: r*h, 255*(l'*ONE + r*h), round and saturate, final selection
	// ---------------------------------------------------------------------------------
	car_t                  car_s14, car_s15;
	logic [PW-1:0]         r_c;
	logic signed [RHW-1:0] rh_s14 [3];
	logic signed [YW-1:0]  y_s15  [3];

	always_comb begin
		unique case (rs_out.mode)
			R_ZERO:  r_c = '0;
			R_ONE:   r_c = ONE;
			R_DIV:   r_c = PW'(rq);
			default: r_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		logic signed [YW-1:0] t;
		if (adv) begin
			car_s14 <= rs_out.car;
			for (int k = 0; k < 3; k++) begin
				rh_s14[k] <= $signed({1'b0, r_c}) * $signed(rs_out.car.h[k]);
			end

			car_s15 <= car_s14;
			for (int k = 0; k < 3; k++) begin
				t = (YW'($signed(car_s14.lp)) <<< F) + YW'(rh_s14[k]);
				y_s15[k] <= (t <<< 8) - t;
			end
		end
	end

	prdl_pkg::pix_out_t res_c, out_s16;

	always_comb begin
		logic [YW-1:0] q;
		logic [7:0]    hv;
		logic [7:0]    src [3];
		logic [7:0]    rv  [3];
		src[0] = car_s15.pix.in_red;
		src[1] = car_s15.pix.in_green;
		src[2] = car_s15.pix.in_blue;
		for (int k = 0; k < 3; k++) begin
			q = (YW'(y_s15[k]) + (YW'(1) << (2 * F - 1))) >> (2 * F);
			if (y_s15[k][YW-1]) begin
				hv = 8'd0;
			end else if (q > YW'(255)) begin
				hv = 8'hFF;
			end else begin
				hv = q[7:0];
			end
			if (car_s15.pass) begin
				rv[k] = src[k];
			end else if (keep_q) begin
				rv[k] = hv;
			end else begin
				rv[k] = car_s15.pln[k];
			end
		end
		res_c.out_red   = rv[0];
		res_c.out_green = rv[1];
		res_c.out_blue  = rv[2];
		res_c.row_done  = car_s15.pix.end_of_row;
		res_c.page_done = car_s15.pix.end_of_page;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_s16 <= res_c;
		end
	end

	assign out_valid = vld_s16;
	assign out_pix   = out_s16;

endmodule
